### src/fqs_pkg.sv
// Shared types and constants for the FIFO queue with search.
// Used by fqs_cell and fifo_queue_with_search_core; no dependencies.
package fqs_pkg;

   // Request kinds carried on req_tuser
   localparam logic [1:0] KIND_PUSH   = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_SEARCH = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_POP_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_PUSH_FULL  = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

   localparam int DATA_W  = 32;
   localparam int POS_W   = 5;
   localparam int RSP_W   = 80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } state_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;     // cell at the tail slot takes the value
      logic pop;      // every cell takes its upper neighbor's entry
      logic compare;  // every cell compares its entry to the key
      logic scan;     // match flags step one cell toward the front
   } cell_ctl_type;

   typedef struct packed {
      logic              is_empty;
      logic [POS_W-1:0]  entry_count;
      logic [DATA_W-1:0] front_value;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] popped_value;
      logic [1:0]        status;
   } result_type;

endpackage

### src/fqs_cell.sv
// One storage cell of the queue chain: holds an entry and a match flag.
// Depends on fqs_pkg for the cell command struct.
module fqs_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                         clock,
   input  fqs_pkg::cell_ctl_type        ctl,
   input  logic [CW-1:0]                count,
   input  logic signed [fqs_pkg::DATA_W-1:0] value,
   input  logic signed [fqs_pkg::DATA_W-1:0] next_entry,
   input  logic                         next_match,
   output logic signed [fqs_pkg::DATA_W-1:0] entry,
   output logic                         match
);

   logic signed [fqs_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                              match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      if (ctl.pop) begin
         entry_in = next_entry;
      end else if (ctl.push && (count == CW'(INDEX))) begin
         entry_in = value;
      end
      if (ctl.compare) begin
         match_in = (entry_ff == value);
      end else if (ctl.scan) begin
         match_in = next_match;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

### src/fifo_queue_with_search_core.sv
// Top level of the FIFO queue with search: cell chain, sequencer, output register.
// Depends on fqs_pkg and fqs_cell.
//
//  - Requests arrive on req_tvalid/req_tready; req_tuser holds the kind
//    (push, pop, search), req_tdata the value or search key. Each accepted
//    request yields exactly one result transfer on rsp_*.
//  - The queue is a chain of DEPTH cells, cell 0 holding the oldest entry.
//    Push writes the cell at the fill count; pop moves every entry one cell
//    toward the front.
//  - Push, pop and unused kinds finish at the accepting edge: the result is
//    loaded into the output register, or into the holding register on a stall.
//  - Search compares all cells to the key, then steps the match flags toward
//    cell 0 one cell per cycle until a match reaches cell 0 after k steps
//    (position k+1) or count steps pass with none (not found).
//  - When the receiver stalls, one more request is still accepted and its
//    result parks in a holding register; no further request is taken until
//    the output drains.
//  - Reset empties the queue and drops any pending result; entry contents are
//    not cleared and are never reported before they are written.
module fifo_queue_with_search_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [33:2] popped_value, [38:34] position,
   // [70:39] front_value, [75:71] entry_count, [76] is_empty, [79:77] zero
   output logic [fqs_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);

   fqs_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   fqs_pkg::result_type   rsp_ff, rsp_in;
   fqs_pkg::result_type   pend_ff, pend_in;
   fqs_pkg::result_type   res;
   logic                  res_valid;
   logic                  out_free;
   logic                  accept;
   fqs_pkg::cell_ctl_type ctl;

   logic signed [fqs_pkg::DATA_W-1:0] value;
   logic [1:0]                        kind;
   logic signed [fqs_pkg::DATA_W-1:0] entry_w [DEPTH];
   logic                              match_w [DEPTH];
   logic signed [fqs_pkg::DATA_W-1:0] front_now;

   assign value    = req_tdata;
   assign kind     = req_tuser;
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign front_now = (count_ff != '0) ? entry_w[0] : '0;

   // Cell chain: each cell hands its entry and match flag to the one below
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [fqs_pkg::DATA_W-1:0] nxt_entry;
      logic                              nxt_match;
      if (i == DEPTH - 1) begin : g_last
         assign nxt_entry = '0;
         assign nxt_match = 1'b0;
      end else begin : g_mid
         assign nxt_entry = entry_w[i+1];
         assign nxt_match = match_w[i+1];
      end
      fqs_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .value      (value),
         .next_entry (nxt_entry),
         .next_match (nxt_match),
         .entry      (entry_w[i]),
         .match      (match_w[i])
      );
   end

   // Sequencer: next state, cell commands and the result of this cycle
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      ctl       = '0;
      res_valid = 1'b0;
      req_tready = 1'b0;
      res.status       = fqs_pkg::STAT_OK;
      res.popped_value = '0;
      res.position     = '0;
      res.front_value  = front_now;

      unique case (state_ff)
         fqs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               res_valid = 1'b1;
               unique case (kind)
                  fqs_pkg::KIND_PUSH: begin
                     if (count_ff < CW'(DEPTH)) begin
                        ctl.push = 1'b1;
                        count_in = count_ff + CW'(1);
                        res.front_value = (count_ff == '0) ? value : entry_w[0];
                     end else begin
                        res.status = fqs_pkg::STAT_PUSH_FULL;
                     end
                  end
                  fqs_pkg::KIND_POP: begin
                     if (count_ff != '0) begin
                        ctl.pop = 1'b1;
                        count_in = count_ff - CW'(1);
                        res.popped_value = entry_w[0];
                        res.front_value  = (count_ff > CW'(1)) ? entry_w[1] : '0;
                     end else begin
                        res.status = fqs_pkg::STAT_POP_EMPTY;
                     end
                  end
                  fqs_pkg::KIND_SEARCH: begin
                     // compare all cells now, walk the flags from next cycle
                     ctl.compare = 1'b1;
                     scan_in   = '0;
                     res_valid = 1'b0;
                     state_in  = fqs_pkg::ST_SCAN;
                  end
                  default: begin
                     // unused kind: report the queue as it stands
                  end
               endcase
               if (res_valid && !out_free) begin
                  state_in = fqs_pkg::ST_HOLD;
               end
            end
         end
         fqs_pkg::ST_SCAN: begin
            if (scan_ff == count_ff) begin
               res_valid  = 1'b1;
               res.status = fqs_pkg::STAT_NOT_FOUND;
            end else if (match_w[0]) begin
               res_valid    = 1'b1;
               res.position = fqs_pkg::POS_W'(scan_ff + CW'(1));
            end else begin
               ctl.scan = 1'b1;
               scan_in  = scan_ff + CW'(1);
            end
            if (res_valid) begin
               state_in = out_free ? fqs_pkg::ST_IDLE : fqs_pkg::ST_HOLD;
            end
         end
         fqs_pkg::ST_HOLD: begin
            if (out_free) begin
               state_in = fqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fqs_pkg::ST_IDLE;
         end
      endcase

      res.entry_count = fqs_pkg::POS_W'(count_in);
      res.is_empty    = (count_in == '0);
   end

   // Output register with a one-deep holding register behind it
   always_comb begin
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if ((state_ff == fqs_pkg::ST_HOLD) && out_free) begin
         rsp_in       = pend_ff;
         rsp_valid_in = 1'b1;
      end else if (res_valid && out_free) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (res_valid) begin
         pend_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fqs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = fqs_pkg::RSP_W'(rsp_ff);

   // Fill count never passes the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds depth");

   // Scan pointer never runs past the held entries
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fqs_pkg::ST_SCAN) |-> (scan_ff <= count_ff))
      else $error("scan pointer past fill count");

   // An accepted push with room grows the queue by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (kind == fqs_pkg::KIND_PUSH) && (count_ff < CW'(DEPTH)))
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not advance fill count");

endmodule

### test/tb.sv
// Self-checking bench for fifo_queue_with_search_core: directed and random push, pop,
// search and unused-kind traffic checked against a cycle-free queue model in the bench.
// Depends on fqs_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 40;    // quiet time after the last result
   localparam int RANDOM_CHUNK = 400;
   localparam int RANDOM_CHUNKS = 3;
   localparam int LONG_HOLD = 100;

   // kind code the block leaves unused; it still answers with one result
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
   } queue_request;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   fifo_queue_with_search_core #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Queue model: ring of entries, head/tail slots and a fill count
   // ---------------------------------------------------------------------
   logic [31:0] ring [QUEUE_DEPTH];
   logic [3:0]  head_slot = '0;
   logic [3:0]  tail_slot = '0;
   logic [4:0]  held = '0;

   function automatic logic [3:0] ring_next(logic [3:0] slot);
      return (slot == QUEUE_DEPTH - 1) ? 4'd0 : slot + 4'd1;
   endfunction

   // Apply one request to the model and return the result it must produce.
   function automatic fqs_pkg::result_type apply_request(logic [1:0] kind,
                                                        logic [31:0] value);
      fqs_pkg::result_type r;
      logic [3:0] slot;
      logic       found;
      r = '0;
      r.status = fqs_pkg::STAT_OK;
      found = 1'b0;
      case (kind)
         fqs_pkg::KIND_PUSH: begin
            if (held == QUEUE_DEPTH) begin
               r.status = fqs_pkg::STAT_PUSH_FULL;   // drop the value
            end else begin
               ring[tail_slot] = value;
               tail_slot = ring_next(tail_slot);
               held = held + 5'd1;
            end
         end
         fqs_pkg::KIND_POP: begin
            if (held == 0) begin
               r.status = fqs_pkg::STAT_POP_EMPTY;
            end else begin
               r.popped_value = ring[head_slot];
               head_slot = ring_next(head_slot);
               held = held - 5'd1;
            end
         end
         fqs_pkg::KIND_SEARCH: begin
            // first match from the oldest entry wins
            r.status = fqs_pkg::STAT_NOT_FOUND;
            slot = head_slot;
            for (int k = 0; k < held; k++) begin
               if (!found && ring[slot] == value) begin
                  found = 1'b1;
                  r.position = 5'(k + 1);
                  r.status = fqs_pkg::STAT_OK;
               end
               slot = ring_next(slot);
            end
         end
         default: begin
            // unused kind: queue untouched, plain ok status
         end
      endcase
      r.front_value = (held != 0) ? ring[head_slot] : '0;
      r.entry_count = held;
      r.is_empty = (held == 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus planning
   // ---------------------------------------------------------------------
   queue_request        pending_ops[$];
   fqs_pkg::result_type expected_results[$];
   logic [31:0]         planned_fill[$];   // contents the queue will hold, for search keys
   int                  error_count = 0;

   // Queue a request and track the contents it leaves behind.
   task automatic plan_request(logic [1:0] kind, logic [31:0] value);
      queue_request op;
      op.kind = kind;
      op.value = value;
      pending_ops.push_back(op);
      if (kind == fqs_pkg::KIND_PUSH && planned_fill.size() < QUEUE_DEPTH)
         planned_fill.push_back(value);
      else if (kind == fqs_pkg::KIND_POP && planned_fill.size() > 0)
         void'(planned_fill.pop_front());
   endtask

   // Values drawn often from a small set so that duplicates and extremes recur.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         5: return 32'h55AA_55AA;
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_ops.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int          roll;
      int          push_pct;
      int          pop_pct;
      int          mode;
      int          mode_left;
      logic [1:0]  kind;
      logic [31:0] value;

      mode = 0;
      mode_left = 0;

      // hold reset at the start, then release it once
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-queue corners, extremes, full queue
      plan_request(fqs_pkg::KIND_POP, 32'h0000_0000);       // pop on empty
      plan_request(fqs_pkg::KIND_SEARCH, 32'h0000_0000);    // search on empty
      plan_request(KIND_UNUSED, 32'hFFFF_FFFF);             // unused kind, all data bits set
      plan_request(fqs_pkg::KIND_PUSH, 32'h8000_0000);
      plan_request(fqs_pkg::KIND_PUSH, 32'h7FFF_FFFF);
      plan_request(fqs_pkg::KIND_PUSH, 32'hFFFF_FFFF);
      plan_request(fqs_pkg::KIND_PUSH, 32'h0000_0000);
      plan_request(fqs_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
      plan_request(fqs_pkg::KIND_SEARCH, 32'h0000_0000);
      plan_request(fqs_pkg::KIND_SEARCH, 32'h0000_0005);    // miss
      plan_request(fqs_pkg::KIND_POP, 32'hA5A5_A5A5);
      for (int i = 0; i < 12; i++)
         plan_request(fqs_pkg::KIND_PUSH, 32'h0000_0100 + i);
      plan_request(fqs_pkg::KIND_PUSH, 32'h5A5A_5A5A);      // queue now full
      plan_request(fqs_pkg::KIND_PUSH, 32'h1234_5678);      // push on full
      plan_request(fqs_pkg::KIND_SEARCH, 32'h5A5A_5A5A);    // match at the last position
      plan_request(fqs_pkg::KIND_SEARCH, 32'h1234_5678);    // dropped value is not found
      wait_drained();

      // Random: phases that lean toward filling, draining or neither
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         for (int n = 0; n < RANDOM_CHUNK; n++) begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 40);
            end
            mode_left--;
            case (mode)
               0: begin push_pct = 60; pop_pct = 15; end
               1: begin push_pct = 15; pop_pct = 60; end
               default: begin push_pct = 35; pop_pct = 30; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               kind = KIND_UNUSED;
               value = $urandom;
            end else if (roll < 4 + push_pct) begin
               kind = fqs_pkg::KIND_PUSH;
               value = pick_value();
            end else if (roll < 4 + push_pct + pop_pct) begin
               kind = fqs_pkg::KIND_POP;
               value = $urandom;
            end else begin
               kind = fqs_pkg::KIND_SEARCH;
               if (planned_fill.size() != 0 && $urandom_range(0, 3) != 0)
                  value = planned_fill[$urandom_range(0, planned_fill.size() - 1)];
               else
                  value = pick_value();
            end
            plan_request(kind, value);
         end
         // pause the sender until every expected result has arrived
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: offer pending requests in bursts, hold each until its transfer
   // ---------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_request(pending_ops[0].kind,
                                                     pending_ops[0].value));
            void'(pending_ops.pop_front());
         end
         // a request still waiting for ready keeps its valid and data
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_ops[0].kind;
               req_tdata <= pending_ops[0].value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready pattern that changes mode, plus long hold-offs that let
   // the block fill up and stall its input
   // ---------------------------------------------------------------------
   int ready_mode = 0;
   int mode_cycles = 0;
   int hold_left = 0;
   int drained_count = 0;
   int next_hold_at = 150;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            drained_count++;
         if (mode_cycles == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_cycles = $urandom_range(16, 96);
         end
         mode_cycles--;
         if (hold_left == 0 && drained_count >= next_hold_at) begin
            hold_left = LONG_HOLD;
            next_hold_at += 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 0);
               2: rsp_tready <= ($urandom_range(0, 9) != 0);
               default: rsp_tready <= (mode_cycles % 4 != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest expectation
   // ---------------------------------------------------------------------
   fqs_pkg::result_type got_result;
   fqs_pkg::result_type want_result;

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: %0h", rsp_tdata);
            error_count++;
         end else begin
            want_result = expected_results.pop_front();
            got_result = rsp_tdata[$bits(fqs_pkg::result_type)-1:0];
            check_field("status", 32'(want_result.status), 32'(got_result.status));
            check_field("popped_value", 32'(want_result.popped_value),
                        32'(got_result.popped_value));
            check_field("position", 32'(want_result.position), 32'(got_result.position));
            check_field("front_value", 32'(want_result.front_value),
                        32'(got_result.front_value));
            check_field("entry_count", 32'(want_result.entry_count),
                        32'(got_result.entry_count));
            check_field("is_empty", 32'(want_result.is_empty), 32'(got_result.is_empty));
            check_field("pad", 32'(0), 32'(rsp_tdata[79:$bits(fqs_pkg::result_type)]));
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sim.f
src/fqs_pkg.sv
src/fqs_cell.sv
src/fifo_queue_with_search_core.sv
test/tb.sv
